[rtl/core/smg_pkg.sv]
// smg_pkg: shared types, constants and the neighbourhood growth function
// for the stochastic mask growth block; no dependencies
`default_nettype none

package smg_pkg;

  // line buffer geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 11;
  localparam int DRAW_W     = 7;
  localparam int ROW_OUT_W  = 10;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;

  // chance weights
  localparam logic [6:0] CHANCE_EDGE  = 7'd15;
  localparam logic [6:0] CHANCE_INNER = 7'd10;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GROW_VALUE   = 2'd2;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one line buffer entry: pixel two rows up, draw and pixel of the row above
  typedef struct packed {
    logic              older;
    logic [DRAW_W-1:0] draw;
    logic              pix;
  } smg_line_t;

  // one result item
  typedef struct packed {
    logic                 pixel;
    logic [COL_W-1:0]     col;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
  } smg_result_t;

  // new value of the middle-row pixel at window slot 1 or 2
  function automatic logic smg_grow(input logic [8:0] win, input logic slot_hi,
                                    input logic [CFG_W-1:0] ccol,
                                    input logic [CFG_W-1:0] row,
                                    input logic [CFG_W-1:0] w,
                                    input logic [CFG_W-1:0] h,
                                    input logic gv, input logic [DRAW_W-1:0] dr);
    int         s;
    int         slot;
    int         col;
    int         rw;
    logic [3:0] bi;
    logic [6:0] chance;
    logic       center;
    s      = slot_hi ? 2 : 1;
    center = win[4'(s * 3 + 1)];
    chance = '0;
    for (int ds = -1; ds <= 1; ds++) begin
      for (int lv = 0; lv <= 2; lv++) begin
        slot = s + ds;
        col  = int'(ccol) + ds;
        rw   = int'(row) - 2 + lv;
        if (slot <= 2 && col >= 0 && col < int'(w) && !(ds == 0 && lv == 1) &&
            rw >= 0 && rw < int'(h)) begin
          bi = 4'(slot * 3 + lv);
          if (win[bi] == gv) begin
            chance = chance + ((col == 0 || rw == 0) ? CHANCE_EDGE : CHANCE_INNER);
          end
        end
      end
    end
    return (center != gv && dr < chance) ? gv : center;
  endfunction

endpackage

`default_nettype wire

[rtl/core/smg_linebuf.sv]
// smg_linebuf: the two line buffers held as one memory with registered read
// and forwarding of a same-address write; depends on smg_pkg
`default_nettype none

module smg_linebuf (
  input  wire                     clk,
  input  wire                     rd_en,
  input  wire [smg_pkg::COL_W-1:0] rd_addr,
  input  wire                     wr_en,
  input  wire [smg_pkg::COL_W-1:0] wr_addr,
  input  wire smg_pkg::smg_line_t wr_data,
  output smg_pkg::smg_line_t      rd_data
);
  import smg_pkg::*;

  smg_line_t mem [MAX_WIDTH];
  smg_line_t rd_word;
  smg_line_t byp_word;
  logic      byp;

  // memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, with capture of a write to the same address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_word <= wr_data;
    end
  end

  assign rd_data = byp ? byp_word : rd_word;

endmodule

`default_nettype wire

[rtl/core/smg_out_fifo.sv]
// smg_out_fifo: result queue taking up to two results per cycle and giving
// one; depends on smg_pkg
`default_nettype none

module smg_out_fifo (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [1:0]                     wr_count,
  input  wire smg_pkg::smg_result_t     wr_data0,
  input  wire smg_pkg::smg_result_t     wr_data1,
  input  wire                           pop,
  output smg_pkg::smg_result_t          rd_data,
  output logic                          rd_valid,
  output logic [smg_pkg::FIFO_AW:0]     level
);
  import smg_pkg::*;

  smg_result_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr1;
  logic               do_pop;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign do_pop  = pop && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr_data0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr1] <= wr_data1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(wr_count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + (FIFO_AW + 1)'(wr_count) - (FIFO_AW + 1)'(do_pop);
    end
  end

  assign rd_valid = (level != '0);
  assign rd_data  = mem[rd_ptr];

endmodule

`default_nettype wire

[rtl/core/stochastic_mask_growth.sv]
// stochastic_mask_growth: top level of the growth pass over a binary mask
// depends on smg_pkg, smg_linebuf and smg_out_fifo
//
// usage
//   input channel (in_valid/in_ready): one raster pixel per transaction with
//   its random draw; after the last row a flush row of image_width
//   transactions with flush high follows
//   output channel (out_valid/out_ready): one new mask pixel per transaction,
//   with its column and row; run_last marks the last result of an input
//   configuration channel (cfg_valid/cfg_ready): cfg_index selects width (0),
//   height (1) or grow value (2); always ready, write only while idle
//   path: a taken input is registered in stage one beside the line buffer read,
//   then its results are written into the queue, one row and one column behind the input
//   throughput: one input per cycle while in_ready is high; the last column
//   of a row gives two results, which the single-result output port sends in turn;
//   a line buffer read stage and an eight-entry result queue set this rate
//   reset: counters, window and queue clear, registers return to 1024, 1024, 1;
//   line buffers are not cleared (the first row only writes them)
//   receiver stall: results wait in the queue; in_ready drops once the queue
//   may not hold the results of the items still in flight
`default_nettype none

module stochastic_mask_growth (
  input  wire                          clk,
  input  wire                          rst,
  // input transactions
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          pixel_in,
  input  wire [smg_pkg::DRAW_W-1:0]    draw,
  input  wire                          flush,
  // output transactions
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         pixel_out,
  output logic [smg_pkg::COL_W-1:0]    out_col,
  output logic [smg_pkg::ROW_OUT_W-1:0] out_row,
  output logic                         run_last,
  // configuration writes
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [1:0]                    cfg_index,
  input  wire [smg_pkg::CFG_W-1:0]     cfg_data
);
  import smg_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             grow_value;
  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;

  // raster counters
  logic [COL_W-1:0] col_count;
  logic [CFG_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [CFG_W-1:0] row_count_next;
  logic             row_end;
  logic             in_take;

  // stage one registers
  logic              s1_valid;
  logic              s1_pix;
  logic [DRAW_W-1:0] s1_draw;
  logic [COL_W-1:0]  s1_col;
  logic [CFG_W-1:0]  s1_row;
  logic              s1_row_end;

  // window state
  logic [8:0]          window_bits;
  logic [2*DRAW_W-1:0] center_draws;
  logic [8:0]          window_next;
  logic [2*DRAW_W-1:0] center_draws_next;

  smg_line_t   line_rd;
  smg_line_t   line_wr;
  smg_result_t res_a;
  smg_result_t res_b;
  smg_result_t push0;
  smg_result_t head;
  logic [1:0]  push_count;
  logic        has_a;
  logic [FIFO_AW:0] fifo_level;
  logic [CFG_W-1:0] ccol_a;
  logic [CFG_W-1:0] ccol_b;

  // configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
      grow_value   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_GROW_VALUE:   grow_value   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective width and height
  always_comb begin
    if (image_width == '0) begin
      eff_w = 11'd1;
    end else if (image_width > CFG_W'(MAX_WIDTH)) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : image_height;
  end

  // input acceptance: room for the results of stage one and the new item
  assign in_ready = ((FIFO_AW + 2)'(fifo_level) + (s1_valid ? 5'd2 : 5'd0))
                    <= (FIFO_AW + 2)'(FIFO_DEPTH - 2);
  assign in_take  = in_valid && in_ready;

  // raster counter update
  always_comb begin
    row_end        = ({1'b0, col_count} + 11'd1) >= eff_w;
    col_count_next = col_count + 1'b1;
    row_count_next = row_count;
    if (row_end) begin
      col_count_next = '0;
      if (row_count >= image_height || row_count >= eff_h) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_take) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage one: hold the transaction while the line buffer is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix     <= flush ? 1'b0 : pixel_in;
      s1_draw    <= draw;
      s1_col     <= col_count;
      s1_row     <= row_count;
      s1_row_end <= row_end;
    end
  end

  smg_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (col_count),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  // line buffer write back: the row above moves down one level
  always_comb begin
    line_wr.older = line_rd.pix;
    line_wr.draw  = s1_draw;
    line_wr.pix   = s1_pix;
  end

  // window shift
  assign window_next       = {s1_pix, line_rd.pix, line_rd.older, window_bits[8:3]};
  assign center_draws_next = {center_draws[DRAW_W-1:0], line_rd.draw};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits  <= '0;
      center_draws <= '0;
    end else if (s1_valid) begin
      window_bits  <= window_next;
      center_draws <= center_draws_next;
    end
  end

  // growth decision for the up to two pixels this item completes
  always_comb begin
    ccol_a = {1'b0, s1_col} - 11'd1;
    ccol_b = {1'b0, s1_col};
    has_a  = (s1_col != '0);

    res_a.pixel = smg_grow(window_next, 1'b0, ccol_a, s1_row, eff_w, eff_h, grow_value,
                           center_draws_next[2*DRAW_W-1:DRAW_W]);
    res_a.col   = ccol_a[COL_W-1:0];
    res_a.row   = ROW_OUT_W'(s1_row - 11'd1);
    res_a.last  = !s1_row_end;

    res_b.pixel = smg_grow(window_next, 1'b1, ccol_b, s1_row, eff_w, eff_h, grow_value,
                           center_draws_next[DRAW_W-1:0]);
    res_b.col   = s1_col;
    res_b.row   = ROW_OUT_W'(s1_row - 11'd1);
    res_b.last  = 1'b1;

    push0 = has_a ? res_a : res_b;
    if (s1_valid && s1_row != '0) begin
      push_count = 2'(has_a) + 2'(s1_row_end);
    end else begin
      push_count = 2'd0;
    end
  end

  smg_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (push_count),
    .wr_data0 (push0),
    .wr_data1 (res_b),
    .pop      (out_ready),
    .rd_data  (head),
    .rd_valid (out_valid),
    .level    (fifo_level)
  );

  // output fields
  assign pixel_out = head.pixel;
  assign out_col   = head.col;
  assign out_row   = head.row;
  assign run_last  = head.last;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (FIFO_AW + 2)'(fifo_level) + (FIFO_AW + 2)'(push_count) <= (FIFO_AW + 2)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_row0_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_row == '0) |-> (push_count == 2'd0))
    else $error("result pushed for the first raster row");

  a_two_needs_end: assert property (@(posedge clk) disable iff (rst)
    (push_count == 2'd2) |-> (s1_row_end && !res_a.last))
    else $error("two results pushed outside a row end");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    ((FIFO_AW + 2)'(fifo_level) > (FIFO_AW + 2)'(FIFO_DEPTH - 2)) |-> !in_ready)
    else $error("input taken with a nearly full result queue");

endmodule

`default_nettype wire

[verif/stochastic_mask_growth_tb.sv]
// testbench for stochastic_mask_growth: directed and random growth passes,
// each result checked against typed-in values or a local model of the growth pass
// depends on smg_pkg and the stochastic_mask_growth rtl
`timescale 1ns / 1ps

module stochastic_mask_growth_tb;
  import smg_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 800;
  // index with no register behind it, writes are ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum bit {STEP_CFG, STEP_PIX} step_kind_t;

  // one row of the directed table
  typedef struct {
    step_kind_t  kind;
    bit [1:0]    reg_idx;
    bit [10:0]   reg_data;
    bit          pin;
    bit [6:0]    dr;
    bit          fl;
    int          typed;    // results typed in below, -1 leaves it to the model
    smg_result_t first_res;
    smg_result_t second_res;
  } plan_row_t;

  // clock, reset and block ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 pixel_in = 1'b0;
  logic [DRAW_W-1:0]    draw = '0;
  logic                 flush = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 pixel_out;
  logic [COL_W-1:0]     out_col;
  logic [ROW_OUT_W-1:0] out_row;
  logic                 run_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // model state: registers, line buffers, window, counters
  bit [10:0]   cfg_width = 11'd1024;
  bit [10:0]   cfg_height = 11'd1024;
  bit          cfg_grow = 1'b1;
  bit [7:0]    recent_line [MAX_WIDTH];
  bit          older_line [MAX_WIDTH];
  bit [8:0]    win;
  bit [13:0]   centre_draws;
  bit [9:0]    col_cnt;
  bit [10:0]   row_cnt;
  smg_result_t step_out [2];

  smg_result_t due_pixels [$];
  plan_row_t   plan [$];
  int          errors = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          tx_idle = 14;
  int          rx_idle = 72;

  stochastic_mask_growth DUT (.*);

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // compare each result transaction with the oldest pixel due
  always @(posedge clk) begin : watch_results
    smg_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_pixels.size() == 0) begin
        report_mismatch("result with none due, out_col", int'(out_col), -1);
      end else begin
        want = due_pixels.pop_front();
        if (pixel_out !== want.pixel)
          report_mismatch($sformatf("pixel_out at row %0d col %0d", want.row, want.col),
                          int'(pixel_out), int'(want.pixel));
        if (out_col !== want.col)
          report_mismatch("out_col", int'(out_col), int'(want.col));
        if (out_row !== want.row)
          report_mismatch("out_row", int'(out_row), int'(want.row));
        if (run_last !== want.last)
          report_mismatch($sformatf("run_last at row %0d col %0d", want.row, want.col),
                          int'(run_last), int'(want.last));
      end
    end
  end

  function automatic int width_eff();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic int height_eff();
    return (cfg_height > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(cfg_height);
  endfunction

  // new value of the middle-row pixel in window slot s at column ccolumn
  function automatic bit grown_pixel(input int s, input int ccolumn, input bit [6:0] dr,
                                     input int w, input int h);
    int chance;
    int slot;
    int colx;
    int rowx;
    bit centre;
    chance = 0;
    centre = win[s * 3 + 1];
    if (centre == cfg_grow) return centre;
    for (int ds = -1; ds <= 1; ds++) begin
      slot = s + ds;
      colx = ccolumn + ds;
      if (slot >= 0 && slot <= 2 && colx >= 0 && colx < w) begin
        for (int lv = 0; lv <= 2; lv++) begin
          rowx = int'(row_cnt) - 2 + lv;
          if (!(ds == 0 && lv == 1) && rowx >= 0 && rowx < h &&
              win[slot * 3 + lv] == cfg_grow) begin
            // border neighbours weigh more
            chance += (colx == 0 || rowx == 0) ? int'(CHANCE_EDGE) : int'(CHANCE_INNER);
          end
        end
      end
    end
    return (int'(dr) < chance) ? cfg_grow : centre;
  endfunction

  // one accepted input: shift the window, update line buffers, fill step_out
  function automatic int grow_step(input bit pin, input bit [6:0] dr, input bit fl);
    int        w;
    int        h;
    int        n;
    bit        pix;
    bit [9:0]  c;
    bit [7:0]  recent;
    bit        row_end;
    w = width_eff();
    h = height_eff();
    pix = fl ? 1'b0 : pin;
    c = col_cnt;
    recent = recent_line[c];
    row_end = (int'(c) + 1 >= w);
    n = 0;
    win = {pix, recent[0], older_line[c], win[8:3]};
    centre_draws = {centre_draws[6:0], recent[7:1]};
    older_line[c] = recent[0];
    recent_line[c] = {dr, pix};
    if (row_cnt >= 1) begin
      if (c >= 1) begin
        step_out[n].pixel = grown_pixel(1, int'(c) - 1, centre_draws[13:7], w, h);
        step_out[n].col = c - 10'd1;
        step_out[n].row = 10'(row_cnt - 11'd1);
        step_out[n].last = !row_end;
        n++;
      end
      // last column emits its own pixel too
      if (row_end) begin
        step_out[n].pixel = grown_pixel(2, int'(c), centre_draws[6:0], w, h);
        step_out[n].col = c;
        step_out[n].row = 10'(row_cnt - 11'd1);
        step_out[n].last = 1'b1;
        n++;
      end
    end
    if (row_end) begin
      col_cnt = '0;
      if (row_cnt >= cfg_height || int'(row_cnt) >= h) row_cnt = '0;
      else row_cnt = row_cnt + 11'd1;
    end else begin
      col_cnt = c + 10'd1;
    end
    return n;
  endfunction

  // input transaction with random sender gaps
  task automatic send_pixel(input bit pin, input bit [6:0] dr, input bit fl,
                            input int typed = -1, input smg_result_t r0 = '0,
                            input smg_result_t r1 = '0);
    int n;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pin;
    draw <= dr;
    flush <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = grow_step(pin, dr, fl);
    if (typed < 0) begin
      for (int i = 0; i < n; i++) due_pixels.push_back(step_out[i]);
    end else begin
      if (typed > 0) due_pixels.push_back(r0);
      if (typed > 1) due_pixels.push_back(r1);
    end
    items_sent++;
  endtask

  // hold the input, let every due pixel arrive and the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bit [1:0] idx, input bit [10:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width = val;
      REG_IMAGE_HEIGHT: cfg_height = val;
      REG_GROW_VALUE:   cfg_grow = val[0];
      default: ;
    endcase
  endtask

  // one whole mask plus its flush row, with the odd flush bit flipped
  task automatic send_image(input int dens);
    bit       begun;
    bit       fl;
    bit [6:0] dr;
    begun = 1'b0;
    while (!begun || row_cnt != 0 || col_cnt != 0) begin
      begun = 1'b1;
      fl = (int'(row_cnt) >= height_eff()) ^ ($urandom_range(99) < 4);
      dr = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(99));
      send_pixel($urandom_range(99) < dens, dr, fl);
    end
  endtask

  function automatic smg_result_t mask_px(input bit p, input int c, input int r, input bit l);
    smg_result_t res;
    res.pixel = p;
    res.col = 10'(c);
    res.row = 10'(r);
    res.last = l;
    return res;
  endfunction

  task automatic plan_cfg(input bit [1:0] idx, input bit [10:0] val);
    plan_row_t item;
    item.kind = STEP_CFG;
    item.reg_idx = idx;
    item.reg_data = val;
    plan.push_back(item);
  endtask

  task automatic plan_pix(input bit pin, input bit [6:0] dr, input bit fl,
                          input int typed = -1, input smg_result_t r0 = '0,
                          input smg_result_t r1 = '0);
    plan_row_t item;
    item.kind = STEP_PIX;
    item.pin = pin;
    item.dr = dr;
    item.fl = fl;
    item.typed = typed;
    item.first_res = r0;
    item.second_res = r1;
    plan.push_back(item);
  endtask

  initial begin
    int big_w [2];
    int big_h [2];
    int big_ph [2];
    int random_items;
    int mark;
    big_w = '{7, 0};
    big_h = '{0, 3};
    big_ph = '{0, 1};
    random_items = 0;

    // 2x2 mask, reset grow value: corner one spreads into the lower row
    plan_cfg(REG_IMAGE_WIDTH, 11'd2);
    plan_cfg(REG_IMAGE_HEIGHT, 11'd2);
    plan_pix(1'b1, 7'd40, 1'b0, 0);
    plan_pix(1'b0, 7'd99, 1'b0, 0);
    plan_pix(1'b0, 7'd0, 1'b0, 0);
    plan_pix(1'b0, 7'd0, 1'b0, 2, mask_px(1, 0, 0, 0), mask_px(0, 1, 0, 1));
    plan_pix(1'b0, 7'd0, 1'b1, 0);
    plan_pix(1'b0, 7'd0, 1'b1, 2, mask_px(1, 0, 1, 0), mask_px(1, 1, 1, 1));
    // zeros spread, draws above 99, flush row with pixel bits set
    plan_cfg(REG_GROW_VALUE, 11'd0);
    plan_pix(1'b0, 7'd127, 1'b0);
    plan_pix(1'b1, 7'd0, 1'b0);
    plan_pix(1'b1, 7'd127, 1'b0);
    plan_pix(1'b0, 7'd14, 1'b0);
    plan_pix(1'b1, 7'd0, 1'b1);
    plan_pix(1'b1, 7'd99, 1'b1);
    // zero width acts as one column
    plan_cfg(REG_IMAGE_WIDTH, 11'd0);
    plan_cfg(REG_IMAGE_HEIGHT, 11'd3);
    plan_pix(1'b1, 7'd5, 1'b0);
    plan_pix(1'b0, 7'd50, 1'b0);
    plan_pix(1'b1, 7'd100, 1'b0);
    plan_pix(1'b0, 7'd0, 1'b1);
    // width and height shrink mid image, write to an unused index
    plan_cfg(REG_UNUSED, 11'h7ff);
    plan_cfg(REG_GROW_VALUE, 11'd1);
    plan_cfg(REG_IMAGE_WIDTH, 11'd3);
    plan_cfg(REG_IMAGE_HEIGHT, 11'd3);
    plan_pix(1'b1, 7'd20, 1'b0);
    plan_pix(1'b0, 7'd3, 1'b0);
    plan_pix(1'b0, 7'd90, 1'b0);
    plan_pix(1'b0, 7'd9, 1'b0);
    plan_cfg(REG_IMAGE_WIDTH, 11'd2);
    plan_pix(1'b1, 7'd60, 1'b0);
    plan_cfg(REG_IMAGE_HEIGHT, 11'd1);
    plan_pix(1'b0, 7'd1, 1'b1);
    plan_pix(1'b0, 7'd2, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_pixel(plan[i].pin, plan[i].dr, plan[i].fl, plan[i].typed,
                   plan[i].first_res, plan[i].second_res);
      end
    end

    // random masks in three idling phases, some closing with odd shapes
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 14 : (ph == 1) ? 72 : 0;
      rx_idle = (ph == 0) ? 72 : (ph == 1) ? 14 : 0;
      while (random_items < (ph + 1) * RANDOM_ITEMS / 3) begin
        write_reg(REG_IMAGE_WIDTH,
                  11'(($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1)));
        write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(8, 1)));
        write_reg(REG_GROW_VALUE, 11'($urandom_range(1)));
        mark = items_sent;
        send_image($urandom_range(90, 10));
        random_items += items_sent - mark;
      end
      for (int k = 0; k < 2; k++) begin
        if (big_ph[k] == ph) begin
          write_reg(REG_IMAGE_WIDTH, 11'(big_w[k]));
          write_reg(REG_IMAGE_HEIGHT, 11'(big_h[k]));
          write_reg(REG_GROW_VALUE, 11'($urandom_range(1)));
          send_image($urandom_range(70, 30));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/smg_pkg.sv
rtl/core/smg_linebuf.sv
rtl/core/smg_out_fifo.sv
rtl/core/stochastic_mask_growth.sv
verif/stochastic_mask_growth_tb.sv
